### rtl/abckw_pkg.sv
// Shared types, constants and helpers for the box-kernel importance weight block.
package abckw_pkg;

	// Fixed field widths
	localparam int WORD_W    = 32;
	localparam int HW_W      = 31;
	localparam int COUNT_W   = 11;
	localparam int NUM_SLOTS = 8;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_PARTICLES = 1024;
	localparam int DEF_NUM_PARAMS    = 8;

	// 1.0 in Q16.16
	localparam logic [WORD_W-1:0] ONE_Q16 = 32'h0001_0000;

	// Request codes
	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_QUERY = 2'd2
	} req_t;

	// Input item
	typedef struct packed {
		req_t               req_type;
		logic               first_round;
		logic [31:0]        past_weight;
		logic signed [31:0] param_0;
		logic signed [31:0] param_1;
		logic signed [31:0] param_2;
		logic signed [31:0] param_3;
		logic signed [31:0] param_4;
		logic signed [31:0] param_5;
		logic signed [31:0] param_6;
		logic signed [31:0] param_7;
	} item_t;

	// Result item
	typedef struct packed {
		logic [31:0]        new_weight;
		logic [COUNT_W-1:0] covering_count;
		logic               store_overflowed;
	} result_t;

	typedef logic [NUM_SLOTS-1:0][WORD_W-1:0] param_vec_t;

	// Gather the parameter fields of an item into a vector, slot 0 lowest
	function automatic param_vec_t item_params(input item_t it);
		param_vec_t v;
		v[0] = it.param_0;
		v[1] = it.param_1;
		v[2] = it.param_2;
		v[3] = it.param_3;
		v[4] = it.param_4;
		v[5] = it.param_5;
		v[6] = it.param_6;
		v[7] = it.param_7;
		return v;
	endfunction

endpackage

### rtl/abckw_store.sv
// Particle store: one parameter row and one weight per particle, registered read.
module abckw_store #(
	parameter int MAX_PARTICLES = abckw_pkg::DEF_MAX_PARTICLES,
	parameter int NUM_PARAMS    = abckw_pkg::DEF_NUM_PARAMS,
	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [AW-1:0]                             wr_addr,
	input  logic [NUM_PARAMS-1:0][abckw_pkg::WORD_W-1:0] wr_params,
	input  logic [abckw_pkg::WORD_W-1:0]              wr_weight,
	input  logic                                      rd_en,
	input  logic [AW-1:0]                             rd_addr,
	output logic [NUM_PARAMS-1:0][abckw_pkg::WORD_W-1:0] rd_params,
	output logic [abckw_pkg::WORD_W-1:0]              rd_weight
);
	import abckw_pkg::*;

	logic [NUM_PARAMS-1:0][WORD_W-1:0] param_mem [MAX_PARTICLES];
	logic [WORD_W-1:0]                 weight_mem [MAX_PARTICLES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			param_mem[wr_addr]  <= wr_params;
			weight_mem[wr_addr] <= wr_weight;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_params <= param_mem[rd_addr];
			rd_weight <= weight_mem[rd_addr];
		end
	end

endmodule

### rtl/abckw_cover.sv
// Box cover test: per-parameter difference, then magnitude against the half-width.
module abckw_cover #(
	parameter int NUM_PARAMS = abckw_pkg::DEF_NUM_PARAMS
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         valid,
	input  logic [NUM_PARAMS-1:0][abckw_pkg::WORD_W-1:0] query,
	input  logic [NUM_PARAMS-1:0][abckw_pkg::HW_W-1:0]   halfwidth,
	input  logic [NUM_PARAMS-1:0][abckw_pkg::WORD_W-1:0] row,
	input  logic [abckw_pkg::WORD_W-1:0]                 weight,
	output logic                                         busy,
	output logic                                         hit_valid,
	output logic                                         hit,
	output logic [abckw_pkg::WORD_W-1:0]                 hit_weight
);
	import abckw_pkg::*;

	logic                                    valid_s2;
	logic                                    valid_s3;
	logic signed [NUM_PARAMS-1:0][WORD_W:0]  diff_s2;
	logic [WORD_W-1:0]                       weight_s2;
	logic                                    hit_s3;
	logic [WORD_W-1:0]                       weight_s3;
	logic [NUM_PARAMS-1:0]                   in_box;

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid;
			valid_s3 <= valid_s2;
		end
	end

	// stage 2: exact 33-bit signed differences
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_PARAMS; i++) begin
			diff_s2[i] <= $signed({query[i][WORD_W-1], query[i]})
				- $signed({row[i][WORD_W-1], row[i]});
		end
		weight_s2 <= weight;
	end

	// magnitude compare per parameter
	always_comb begin
		logic [WORD_W:0] mag;
		for (int i = 0; i < NUM_PARAMS; i++) begin
			mag       = diff_s2[i][WORD_W] ? (WORD_W+1)'(-diff_s2[i]) : diff_s2[i];
			in_box[i] = (mag <= {2'b00, halfwidth[i]});
		end
	end

	// stage 3: all parameters inside the box
	always_ff @(posedge clk) begin
		hit_s3    <= &in_box;
		weight_s3 <= weight_s2;
	end

	assign busy       = valid_s2 | valid_s3;
	assign hit_valid  = valid_s3;
	assign hit        = hit_s3;
	assign hit_weight = weight_s3;

endmodule

### rtl/abckw_recip.sv
// Restoring divider: floor(2^32 / sum) one quotient bit a cycle, saturated, 0 gives 1.0.
module abckw_recip #(
	parameter int SUM_W = abckw_pkg::WORD_W + 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SUM_W-1:0]             divisor,
	output logic                         done,
	output logic [abckw_pkg::WORD_W-1:0] quotient
);
	import abckw_pkg::*;

	localparam int STEPS  = WORD_W + 1;
	localparam int STEP_W = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  div_q;
	logic [SUM_W-1:0]  rem_q;
	logic [WORD_W:0]   quo_q;
	logic              zero_q;
	logic [SUM_W:0]    rem_sh;
	logic [SUM_W:0]    rem_next;
	logic              ge;

	// one restoring step; the dividend 2^32 has its only set bit first
	always_comb begin
		rem_sh   = {rem_q, (step_q == '0)};
		ge       = (rem_sh >= {1'b0, div_q});
		rem_next = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= (divisor != '0);
			done_q <= (divisor == '0);
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= divisor;
			zero_q <= (divisor == '0);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next[SUM_W-1:0];
			quo_q <= {quo_q[WORD_W-1:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? ONE_Q16 : (quo_q[WORD_W] ? '1 : quo_q[WORD_W-1:0]);

endmodule

### rtl/abc_smc_box_kernel_weight_core.sv
// Box-kernel importance weight core: particle store, cover scan and reciprocal unit.
//
// Loads and clears are handled in the idle state and do not leave it. A query
// that is not first-round and finds a non-empty store reads the stored particles
// one per cycle through the single store read port and the cover unit, then
// waits for the read and compare pipeline to drain, runs the bit-serial
// reciprocal (one quotient bit per cycle over 33 bits) and posts the result.
// A zero covering sum skips the quotient steps. A first-round query or one
// against an empty store goes straight to posting its result, with no scan and
// no reciprocal. item_stall is high while a query is in work. The result
// register frees the input side: loads and clears are taken while a result
// waits on result_stall, and a query that finishes meanwhile holds in its
// done state until that result is taken. No clearing pass is needed after reset.
// Half-widths are written over APB at byte address 4*i.
module abc_smc_box_kernel_weight_core #(
	parameter int MAX_PARTICLES = abckw_pkg::DEF_MAX_PARTICLES,
	parameter int NUM_PARAMS    = abckw_pkg::DEF_NUM_PARAMS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  abckw_pkg::item_t                item,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output abckw_pkg::result_t              result,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [abckw_pkg::PADDR_W-1:0]   paddr,
	input  logic [abckw_pkg::PDATA_W-1:0]   pwdata,
	output logic [abckw_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	import abckw_pkg::*;

	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int SW = WORD_W + CW;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                             state_q;
	logic [NUM_SLOTS-1:0][HW_W-1:0]     hw_q;
	logic [CW-1:0]                      stored_q;
	logic                               ovf_q;
	logic [CW-1:0]                      scan_q;
	logic                               issue_s1;
	logic [NUM_PARAMS-1:0][WORD_W-1:0]  query_q;
	logic [SW-1:0]                      sum_q;
	logic [CW-1:0]                      cnt_q;
	logic [WORD_W-1:0]                  weight_q;
	logic                               result_valid_q;
	result_t                            result_q;

	logic                               accept;
	logic                               store_full;
	logic                               wr_en;
	param_vec_t                         item_vec;
	logic [NUM_PARAMS-1:0][WORD_W-1:0]  rd_params;
	logic [WORD_W-1:0]                  rd_weight;
	logic                               cov_busy;
	logic                               hit_valid;
	logic                               hit;
	logic [WORD_W-1:0]                  hit_weight;
	logic                               drained;
	logic                               div_done;
	logic [WORD_W-1:0]                  quotient;
	logic                               res_free;

	// handshakes
	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid & ~item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign res_free     = ~result_valid_q | ~result_stall;

	assign item_vec   = item_params(item);
	assign store_full = (stored_q == CW'(MAX_PARTICLES));
	assign wr_en      = accept && (item.req_type == REQ_LOAD) && !store_full;
	assign drained    = ~issue_s1 & ~cov_busy;

	// configuration registers
	assign pready = 1'b1;
	assign prdata = {1'b0, hw_q[paddr[PADDR_W-1:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '0;
		end else if (psel && penable && pwrite) begin
			hw_q[paddr[PADDR_W-1:2]] <= pwdata[HW_W-1:0];
		end
	end

	// sequencer and store bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			stored_q       <= '0;
			ovf_q          <= 1'b0;
			scan_q         <= '0;
			issue_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			issue_s1 <= (state_q == ST_SCAN);
			// result valid: set when posted, cleared when taken
			if (state_q == ST_DONE && res_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.req_type)
							REQ_CLEAR: begin
								stored_q <= '0;
								ovf_q    <= 1'b0;
							end
							REQ_LOAD: begin
								if (store_full) begin
									ovf_q <= 1'b1;
								end else begin
									stored_q <= stored_q + 1'b1;
								end
							end
							REQ_QUERY: begin
								scan_q <= '0;
								if (item.first_round || stored_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == stored_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query payload, accumulators and result register
	always_ff @(posedge clk) begin
		if (accept && item.req_type == REQ_QUERY) begin
			query_q  <= item_vec[NUM_PARAMS-1:0];
			sum_q    <= '0;
			cnt_q    <= '0;
			weight_q <= ONE_Q16;
		end
		if (hit_valid && hit) begin
			sum_q <= sum_q + SW'(hit_weight);
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == ST_DIV && div_done) begin
			weight_q <= quotient;
		end
		if (state_q == ST_DONE && res_free) begin
			result_q.new_weight       <= weight_q;
			result_q.covering_count   <= COUNT_W'(cnt_q);
			result_q.store_overflowed <= ovf_q;
		end
	end

	abckw_store #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.NUM_PARAMS    (NUM_PARAMS)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (stored_q[AW-1:0]),
		.wr_params (item_vec[NUM_PARAMS-1:0]),
		.wr_weight (item.past_weight),
		.rd_en     (state_q == ST_SCAN),
		.rd_addr   (scan_q[AW-1:0]),
		.rd_params (rd_params),
		.rd_weight (rd_weight)
	);

	abckw_cover #(
		.NUM_PARAMS (NUM_PARAMS)
	) u_cover (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (issue_s1),
		.query      (query_q),
		.halfwidth  (hw_q[NUM_PARAMS-1:0]),
		.row        (rd_params),
		.weight     (rd_weight),
		.busy       (cov_busy),
		.hit_valid  (hit_valid),
		.hit        (hit),
		.hit_weight (hit_weight)
	);

	abckw_recip #(
		.SUM_W (SW)
	) u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DRAIN && drained),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (quotient)
	);

endmodule
